[hdl/cfc_pkg.sv]
// shared types, constants and the rounding helper of the complex fir convolver
package cfc_pkg;

  localparam int TAPS_DEF = 256;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 40;
  localparam int PROD_W   = 33;
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DRAIN  = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic coef_we;
    logic active;
  } cell_ctrl_t;

  // round half up at bit 15 and saturate a 40-bit sum to q1.15
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W:0] t;
    logic signed [ACC_W-15:0] q;
    t = (ACC_W+1)'(v) + (ACC_W+1)'(16384);
    q = (ACC_W-14)'(t >>> 15);
    if (q > (ACC_W-14)'(32767)) begin
      return 16'sh7fff;
    end else if (q < -(ACC_W-14)'(32768)) begin
      return 16'sh8000;
    end
    return SAMPLE_W'(q);
  endfunction

endpackage

[hdl/cfc_cell.sv]
// one tap cell: coefficient, complex product and pending partial sum
module cfc_cell (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  cfc_pkg::cell_ctrl_t                       ctrl_i,
  input  logic signed [cfc_pkg::SAMPLE_W-1:0]       x_re_i,
  input  logic signed [cfc_pkg::SAMPLE_W-1:0]       x_im_i,
  input  logic signed [cfc_pkg::SAMPLE_W-1:0]       coef_re_i,
  input  logic signed [cfc_pkg::SAMPLE_W-1:0]       coef_im_i,
  input  logic signed [cfc_pkg::ACC_W-1:0]          psum_re_i,
  input  logic signed [cfc_pkg::ACC_W-1:0]          psum_im_i,
  output logic signed [cfc_pkg::ACC_W-1:0]          sum_re_o,
  output logic signed [cfc_pkg::ACC_W-1:0]          sum_im_o
);

  logic signed [cfc_pkg::SAMPLE_W-1:0] h_re_q, h_im_q;
  logic signed [cfc_pkg::PROD_W-1:0]   prod_re_q, prod_re_d;
  logic signed [cfc_pkg::PROD_W-1:0]   prod_im_q, prod_im_d;
  logic signed [cfc_pkg::ACC_W-1:0]    psum_re_q, psum_im_q;
  logic signed [2*cfc_pkg::SAMPLE_W-1:0] p_rr, p_ii, p_ri, p_ir;

  assign p_rr = x_re_i * h_re_q;
  assign p_ii = x_im_i * h_im_q;
  assign p_ri = x_re_i * h_im_q;
  assign p_ir = x_im_i * h_re_q;

  assign prod_re_d = cfc_pkg::PROD_W'(p_rr) - cfc_pkg::PROD_W'(p_ii);
  assign prod_im_d = cfc_pkg::PROD_W'(p_ri) + cfc_pkg::PROD_W'(p_ir);

  // pending sum plus this tap's contribution, wrapping at 40 bits
  always_comb begin
    sum_re_o = psum_re_q;
    sum_im_o = psum_im_q;
    if (ctrl_i.active) begin
      sum_re_o = psum_re_q + cfc_pkg::ACC_W'(prod_re_q);
      sum_im_o = psum_im_q + cfc_pkg::ACC_W'(prod_im_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_re_q    <= '0;
      h_im_q    <= '0;
      prod_re_q <= '0;
      prod_im_q <= '0;
      psum_re_q <= '0;
      psum_im_q <= '0;
    end else begin
      if (ctrl_i.coef_we) begin
        h_re_q <= coef_re_i;
        h_im_q <= coef_im_i;
      end
      if (ctrl_i.mul_en) begin
        prod_re_q <= prod_re_d;
        prod_im_q <= prod_im_d;
      end
      // shift toward cell zero: take the neighbor's updated sum
      if (ctrl_i.acc_en) begin
        psum_re_q <= psum_re_i;
        psum_im_q <= psum_im_i;
      end
    end
  end

endmodule

[hdl/complex_fir_convolver_unit.sv]
// top level of the streaming complex fir convolver built as a chain of tap cells
// a sample or drain request steps through multiply, accumulate and shift along the cell chain,
//   and round into the output register; no new request is taken until it is back in idle, and
//   the round step waits while the output register is full; a load-tap or empty drain stays in idle
// reset: asynchronous, clears coefficients, partial sums, tail count; tap_count = 1
module complex_fir_convolver_unit #(
  parameter int TAPS = cfc_pkg::TAPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: tap_count
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_re[15:0], sample_im[31:16], tap_index[39:32], tap_re[55:40], tap_im[71:56]
  input  logic [71:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_re[15:0], out_im[31:16]
  output logic [31:0] m_axis_tdata,
  // last_of_tail
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_OUT
  } state_e;

  localparam int SW = cfc_pkg::SAMPLE_W;
  localparam int AW = cfc_pkg::ACC_W;
  localparam int CW = cfc_pkg::COUNT_W;

  state_e state_q;

  logic [CW-1:0] tap_count_q;
  logic [CW-1:0] tail_q;
  logic [CW-1:0] taps_used;

  logic signed [SW-1:0] x_re_q, x_im_q;
  logic                 last_q;
  logic signed [AW-1:0] sum_re_q, sum_im_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_re_q, out_im_q;
  logic                 out_last_q;

  // request fields
  logic signed [SW-1:0]           in_sample_re, in_sample_im;
  logic [cfc_pkg::INDEX_W-1:0]    in_tap_index;
  logic signed [SW-1:0]           in_tap_re, in_tap_im;

  assign in_sample_re = s_axis_tdata[15:0];
  assign in_sample_im = s_axis_tdata[31:16];
  assign in_tap_index = s_axis_tdata[39:32];
  assign in_tap_re    = s_axis_tdata[55:40];
  assign in_tap_im    = s_axis_tdata[71:56];

  logic req_fire;
  logic load_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign req_fire      = s_axis_tvalid && s_axis_tready;
  // coefficients change only while no tail is pending
  assign load_fire     = req_fire && (s_axis_tuser == cfc_pkg::KIND_LOAD) && (tail_q == '0);

  // taps in use: zero counts as one, larger than the chain saturates
  always_comb begin
    taps_used = tap_count_q;
    if (tap_count_q == '0) begin
      taps_used = CW'(1);
    end else if (int'(tap_count_q) > TAPS) begin
      taps_used = CW'(TAPS);
    end
  end

  // chain of cells, sums flow toward cell zero
  logic signed [AW-1:0] cell_sum_re [TAPS];
  logic signed [AW-1:0] cell_sum_im [TAPS];

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    cfc_pkg::cell_ctrl_t  ctrl;
    logic signed [AW-1:0] nb_re, nb_im;

    assign ctrl.mul_en  = (state_q == S_MUL);
    assign ctrl.acc_en  = (state_q == S_ACC);
    assign ctrl.coef_we = load_fire && (int'(in_tap_index) == k);
    assign ctrl.active  = (int'(taps_used) > k);

    // the far end of the chain shifts in an empty sum
    if (k == TAPS - 1) begin : g_end
      assign nb_re = '0;
      assign nb_im = '0;
    end else begin : g_mid
      assign nb_re = cell_sum_re[k+1];
      assign nb_im = cell_sum_im[k+1];
    end

    cfc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .x_re_i    (x_re_q),
      .x_im_i    (x_im_q),
      .coef_re_i (in_tap_re),
      .coef_im_i (in_tap_im),
      .psum_re_i (nb_re),
      .psum_im_i (nb_im),
      .sum_re_o  (cell_sum_re[k]),
      .sum_im_o  (cell_sum_im[k])
    );
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_count_q <= CW'(1);
      tail_q      <= '0;
      x_re_q      <= '0;
      x_im_q      <= '0;
      last_q      <= 1'b0;
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      out_valid_q <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // config ignored while a tail is pending
      if (cfg_we_i && (tail_q == '0)) begin
        tap_count_q <= cfg_wdata_i;
      end

      // new result loaded when the register is free, else cleared once taken downstream
      if ((state_q == S_OUT) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            case (s_axis_tuser)
              cfc_pkg::KIND_SAMPLE: begin
                x_re_q  <= in_sample_re;
                x_im_q  <= in_sample_im;
                last_q  <= 1'b0;
                tail_q  <= taps_used - CW'(1);
                state_q <= S_MUL;
              end
              cfc_pkg::KIND_DRAIN: begin
                // empty tail: request consumed, no result
                if (tail_q != '0) begin
                  x_re_q  <= '0;
                  x_im_q  <= '0;
                  last_q  <= (tail_q == CW'(1));
                  tail_q  <= tail_q - CW'(1);
                  state_q <= S_MUL;
                end
              end
              default: begin
                // load-tap handled by the cell write enables, unused kind dropped
              end
            endcase
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          // cell zero's updated sum is the result before the shift
          sum_re_q <= cell_sum_re[0];
          sum_im_q <= cell_sum_im[0];
          state_q  <= S_OUT;
        end
        S_OUT: begin
          // wait until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_re_q    <= cfc_pkg::round_sat(sum_re_q);
            out_im_q    <= cfc_pkg::round_sat(sum_im_q);
            out_last_q  <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_im_q, out_re_q};
  assign m_axis_tlast  = out_last_q;

endmodule
